/* sv/lpd_pkg.sv */
// ----------------------------------------------------------------------------
// lpd_pkg
// Types and constants shared by the length-prefix deframer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package lpd_pkg;

    // Length header size in bytes, most significant byte first
    localparam int unsigned HDR_BYTES  = 4;
    localparam int unsigned HCNT_W     = $clog2(HDR_BYTES);
    localparam logic [HCNT_W-1:0] HDR_LAST = HCNT_W'(HDR_BYTES - 1);

    // Register and length widths
    localparam int unsigned LEN_W      = 24;
    localparam int unsigned HDR_W      = 8 * HDR_BYTES;
    localparam int unsigned SHIFT_W    = HDR_W - 8;
    localparam logic [LEN_W-1:0] MAX_LEN_RESET = LEN_W'(10 * 1024 * 1024);

    // Input action codes
    localparam logic ACT_DATA  = 1'b0;
    localparam logic ACT_CLOSE = 1'b1;

    // Deframer phase
    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_ERROR   = 2'd2
    } t_phase;

    // Result kind
    typedef enum logic [1:0] {
        KIND_BYTE   = 2'd0,
        KIND_BADLEN = 2'd1,
        KIND_ABORT  = 2'd2
    } t_kind;

    // One result from the frame state machine
    typedef struct packed {
        logic       valid;
        t_kind      kind;
        logic [7:0] data;
        logic       last;
    } t_result;

endpackage

`default_nettype wire

/* sv/lpd_frame_fsm.sv */
// ----------------------------------------------------------------------------
// lpd_frame_fsm
// Frame state machine: collects the length header, counts payload bytes,
// and produces at most one result per processed transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module lpd_frame_fsm
    import lpd_pkg::*;
(
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_step,
    input  wire              i_action,
    input  wire [7:0]        i_data_byte,
    input  wire [LEN_W-1:0]  i_max_len,
    output t_result          o_result
);

    t_phase              r_phase, n_phase;
    logic [HCNT_W-1:0]   r_hcnt,  n_hcnt;
    logic [SHIFT_W-1:0]  r_len,   n_len;
    logic [LEN_W-1:0]    r_rem,   n_rem;

    logic [HDR_W-1:0]    w_len_full;
    logic                w_bad_len;
    logic                w_mid;
    logic                w_last;

    // Full header value once the final byte arrives
    assign w_len_full = {r_len, i_data_byte};
    assign w_bad_len  = (w_len_full == '0)
                     || (w_len_full[HDR_W-1:LEN_W] != '0)
                     || (w_len_full[LEN_W-1:0] > i_max_len);
    assign w_mid      = (r_phase == PH_PAYLOAD)
                     || ((r_phase != PH_ERROR) && (r_hcnt != '0));
    assign w_last     = (r_rem <= LEN_W'(1));

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_hcnt  <= '0;
            r_rem   <= '0;
        end else begin
            r_phase <= n_phase;
            r_hcnt  <= n_hcnt;
            r_rem   <= n_rem;
        end
    end

    // Header shift register; each header byte shifts in, pushing older bytes out
    always_ff @(posedge i_clk) begin
        r_len <= n_len;
    end

    // Next state and result
    always_comb begin
        n_phase  = r_phase;
        n_hcnt   = r_hcnt;
        n_len    = r_len;
        n_rem    = r_rem;
        o_result = '{valid: 1'b0, kind: KIND_BYTE, data: 8'd0, last: 1'b0};
        if (i_step) begin
            if (i_action == ACT_CLOSE) begin
                // Clear state; report a partial frame as aborted
                n_phase         = PH_HEADER;
                n_hcnt          = '0;
                n_rem           = '0;
                o_result.valid  = w_mid;
                o_result.kind   = KIND_ABORT;
            end else begin
                unique case (r_phase)
                    PH_ERROR: begin
                        // Drop bytes until close
                    end
                    PH_PAYLOAD: begin
                        o_result.valid = 1'b1;
                        o_result.kind  = KIND_BYTE;
                        o_result.data  = i_data_byte;
                        o_result.last  = w_last;
                        if (w_last) begin
                            n_phase = PH_HEADER;
                            n_rem   = '0;
                        end else begin
                            n_rem   = r_rem - LEN_W'(1);
                        end
                    end
                    default: begin
                        // Header phase: shift in one length byte
                        n_len = w_len_full[SHIFT_W-1:0];
                        if (r_hcnt == HDR_LAST) begin
                            n_hcnt = '0;
                            if (w_bad_len) begin
                                n_phase        = PH_ERROR;
                                n_rem          = '0;
                                o_result.valid = 1'b1;
                                o_result.kind  = KIND_BADLEN;
                            end else begin
                                n_phase = PH_PAYLOAD;
                                n_rem   = w_len_full[LEN_W-1:0];
                            end
                        end else begin
                            n_hcnt = r_hcnt + HCNT_W'(1);
                        end
                    end
                endcase
            end
        end
    end

    // A partial header only exists in the header phase
    a_hcnt_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hcnt != '0) |-> (r_phase == PH_HEADER))
        else $error("header count set outside header phase");

    // Payload countdown only runs in the payload phase
    a_rem_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rem != '0) |-> (r_phase == PH_PAYLOAD))
        else $error("bytes remaining outside payload phase");

    // A close always returns to an empty header phase
    a_close_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && (i_action == ACT_CLOSE))
            |=> ((r_phase == PH_HEADER) && (r_hcnt == '0) && (r_rem == '0)))
        else $error("close did not clear state");

    // Entering payload phase always loads a nonzero count
    a_payload_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_phase == PH_PAYLOAD) && !$past(r_phase == PH_PAYLOAD)
            && $past(i_rst_n)) |-> (r_rem != '0))
        else $error("payload phase entered with zero length");

endmodule

`default_nettype wire

/* sv/length_prefix_deframer.sv */
// ----------------------------------------------------------------------------
// length_prefix_deframer
// Splits a byte stream into length-prefixed frames and streams the payload
// bytes out, flagging bad lengths and frames cut short by a close.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake                  Payload
//  in       input      i_in_valid / o_in_stall    i_action, i_data_byte
//  out      output     o_out_valid / i_out_stall  o_kind, o_payload_byte,
//                                                 o_last_byte
//  cfg      input      i_cfg_we                   i_cfg_wdata (max length)
//
//  One transaction per cycle while the output is not stalled: input
//  register, one pass of the frame state machine, result register.
//  Reset is synchronous; the maximum length returns to 10 MiB.
//  An output stall holds a valid result register and, once the input register
//  also holds a transaction, raises o_in_stall.
// ----------------------------------------------------------------------------
`default_nettype none

module length_prefix_deframer
    import lpd_pkg::*;
(
    input  wire              i_clk,
    input  wire              i_rst_n,
    // Configuration
    input  wire              i_cfg_we,
    input  wire [LEN_W-1:0]  i_cfg_wdata,
    // Input channel
    input  wire              i_in_valid,
    output logic             o_in_stall,
    input  wire              i_action,
    input  wire [7:0]        i_data_byte,
    // Output channel
    output logic             o_out_valid,
    input  wire              i_out_stall,
    output logic [1:0]       o_kind,
    output logic [7:0]       o_payload_byte,
    output logic             o_last_byte
);

    logic [LEN_W-1:0] r_max_len;

    logic             r_in_valid;
    logic             r_in_action;
    logic [7:0]       r_in_byte;

    logic             r_out_valid;
    t_kind            r_out_kind;
    logic [7:0]       r_out_byte;
    logic             r_out_last;

    logic             w_out_free;
    logic             w_step;
    t_result          w_result;

    // Result register can take a new value
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_step     = r_in_valid && w_out_free;
    assign o_in_stall = r_in_valid && !w_out_free;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_LEN_RESET;
        end else if (i_cfg_we) begin
            r_max_len <= i_cfg_wdata;
        end
    end

    // Input register: advance when not stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_action <= i_action;
            r_in_byte   <= i_data_byte;
        end
    end

    lpd_frame_fsm u_fsm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_step),
        .i_action    (r_in_action),
        .i_data_byte (r_in_byte),
        .i_max_len   (r_max_len),
        .o_result    (w_result)
    );

    // Result register: load when free, hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && w_result.valid) begin
            r_out_kind <= w_result.kind;
            r_out_byte <= w_result.data;
            r_out_last <= w_result.last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_out_kind;
    assign o_payload_byte = r_out_byte;
    assign o_last_byte    = r_out_last;

endmodule

`default_nettype wire
